// ----- sv/bks_pkg.sv -----
// bks_pkg: shared types, operation codes and defaults for the bounded key set
// used by bounded_key_set_core and bks_checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bks_pkg;

	// fixed field widths of the transaction payloads
	localparam int CMD_W        = 2;
	localparam int KEY_FIELD_W  = 32;
	localparam int FILL_W       = 5;
	localparam int MAX_KEY_W    = 64;

	// parameter defaults
	localparam int CAPACITY_DEF  = 16;
	localparam int KEY_WIDTH_DEF = 32;

	// operation codes
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]       cmd;
		logic [KEY_FIELD_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic [FILL_W-1:0] fill_count;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT
	} state_t;

endpackage

`default_nettype wire

// ----- sv/bks_ram.sv -----
// bks_ram: generic simple dual-port ram, one write port and one registered read port
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module bks_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic                                       re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/bounded_key_set_core.sv -----
// bounded_key_set_core: fixed capacity key set, packed in insertion order, with compaction
// depends on bks_pkg and bks_ram
//
//  channel   dir  handshake               payload
//  request   in   start & !busy           req  (bks_pkg::req_t: cmd, key)
//  result    out  done, one cycle strobe  rsp  (bks_pkg::rsp_t: ok, fill_count)
//
//  - keys live in one ram with a registered read; the scan reads one entry per cycle
//    and compares it in the next cycle, so the ram read port sets the pace
//  - lookup / insert: the scan runs over every entry on a miss and stops at a hit; an empty
//    set, a full set on insert or an unused code answers straight from idle, without a scan
//  - erase: as lookup up to the hit, then the entries above the hit move down one place
//  - reset clears state and fill count at once; ram contents need no clearing
//  - the receiver cannot stall: each result shows for exactly one cycle, and a new
//    transaction may be taken in that same cycle
`timescale 1ns / 1ps
`default_nettype none

module bounded_key_set_core #(
	parameter int CAPACITY  = bks_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = bks_pkg::KEY_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output      logic          busy,
	input  wire bks_pkg::req_t req,
	output      logic          done,
	output      bks_pkg::rsp_t rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

	// sequencer state
	bks_pkg::state_t state_q, state_d;

	// latched transaction
	logic [bks_pkg::CMD_W-1:0] cmd_q, cmd_d;
	logic [KEY_WIDTH-1:0]      key_q, key_d;

	// fill count
	logic [CNT_W-1:0] count_q, count_d;

	// scan: address being read, and the address whose data is on the ram output
	logic [CNT_W-1:0] scan_idx_q, scan_idx_d;
	logic             cmp_vld_s1, cmp_vld_d;
	logic [CNT_W-1:0] cmp_idx_s1, cmp_idx_d;

	// shift: next entry to read, and the pending write-back one place lower
	logic [CNT_W-1:0] sh_rd_q, sh_rd_d;
	logic             wr_pend_s1, wr_pend_d;
	logic [IDX_W-1:0] wr_addr_s1, wr_addr_d;

	// result register
	logic  done_q, done_d;
	logic  ok_q, ok_d;

	// ram ports
	logic                 ram_we, ram_re;
	logic [IDX_W-1:0]     ram_waddr, ram_raddr;
	logic [KEY_WIDTH-1:0] ram_wdata, ram_rdata;

	logic                               accept;
	logic [bks_pkg::MAX_KEY_W-1:0]      key_wide;
	logic [KEY_WIDTH-1:0]               key_in;
	logic [CNT_W-1:0]                   count_m1;
	logic                               hit, last_cmp, scan_issue, sh_issue;
	logic [CNT_W+bks_pkg::FILL_W-1:0]   fill_wide_q;

	assign busy   = (state_q != bks_pkg::ST_IDLE);
	assign accept = start && !busy;

	// only the low KEY_WIDTH bits of the key field take part
	assign key_wide = {{(bks_pkg::MAX_KEY_W - bks_pkg::KEY_FIELD_W){1'b0}}, req.key};
	assign key_in   = key_wide[KEY_WIDTH-1:0];

	assign count_m1   = count_q - ONE_CNT;
	assign hit        = cmp_vld_s1 && (ram_rdata == key_q);
	assign last_cmp   = cmp_vld_s1 && (cmp_idx_s1 == count_m1);
	assign scan_issue = (state_q == bks_pkg::ST_SCAN) && (scan_idx_q < count_q);
	assign sh_issue   = (state_q == bks_pkg::ST_SHIFT) && (sh_rd_q < count_q);

	bks_ram #(
		.WIDTH(KEY_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bks_pkg::ST_IDLE;
			count_q    <= '0;
			cmp_vld_s1 <= 1'b0;
			wr_pend_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			cmp_vld_s1 <= cmp_vld_d;
			wr_pend_s1 <= wr_pend_d;
			done_q     <= done_d;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		cmd_q      <= cmd_d;
		key_q      <= key_d;
		scan_idx_q <= scan_idx_d;
		cmp_idx_s1 <= cmp_idx_d;
		sh_rd_q    <= sh_rd_d;
		wr_addr_s1 <= wr_addr_d;
		ok_q       <= ok_d;
	end

	always_comb begin
		state_d    = state_q;
		cmd_d      = cmd_q;
		key_d      = key_q;
		count_d    = count_q;
		scan_idx_d = scan_idx_q;
		cmp_vld_d  = 1'b0;
		cmp_idx_d  = scan_idx_q;
		sh_rd_d    = sh_rd_q;
		wr_pend_d  = 1'b0;
		wr_addr_d  = wr_addr_s1;
		done_d     = 1'b0;
		ok_d       = ok_q;
		ram_we     = 1'b0;
		ram_waddr  = count_q[IDX_W-1:0];
		ram_wdata  = key_q;
		ram_re     = 1'b0;
		ram_raddr  = scan_idx_q[IDX_W-1:0];

		case (state_q)
			bks_pkg::ST_IDLE: begin
				if (accept) begin
					cmd_d      = req.cmd;
					key_d      = key_in;
					scan_idx_d = '0;
					case (req.cmd)
						bks_pkg::CMD_LOOKUP, bks_pkg::CMD_ERASE: begin
							if (count_q == '0) begin
								done_d = 1'b1;
								ok_d   = 1'b0;
							end else begin
								state_d = bks_pkg::ST_SCAN;
							end
						end
						bks_pkg::CMD_INSERT: begin
							if (count_q == CAP_CNT) begin
								// full set: no room whatever the scan would say
								done_d = 1'b1;
								ok_d   = 1'b0;
							end else if (count_q == '0) begin
								// empty set: append straight away
								ram_we    = 1'b1;
								ram_wdata = key_in;
								count_d   = ONE_CNT;
								done_d    = 1'b1;
								ok_d      = 1'b1;
							end else begin
								state_d = bks_pkg::ST_SCAN;
							end
						end
						default: begin
							// unused code changes nothing
							done_d = 1'b1;
							ok_d   = 1'b0;
						end
					endcase
				end
			end

			bks_pkg::ST_SCAN: begin
				// read ahead one entry per cycle
				if (scan_issue) begin
					ram_re     = 1'b1;
					scan_idx_d = scan_idx_q + ONE_CNT;
				end
				cmp_vld_d = scan_issue;
				cmp_idx_d = scan_idx_q;

				if (hit) begin
					cmp_vld_d = 1'b0;
					case (cmd_q)
						bks_pkg::CMD_ERASE: begin
							if (cmp_idx_s1 == count_m1) begin
								// last entry: nothing to move down
								count_d = count_m1;
								done_d  = 1'b1;
								ok_d    = 1'b1;
								state_d = bks_pkg::ST_IDLE;
							end else begin
								sh_rd_d = cmp_idx_s1 + ONE_CNT;
								state_d = bks_pkg::ST_SHIFT;
							end
						end
						bks_pkg::CMD_LOOKUP: begin
							done_d  = 1'b1;
							ok_d    = 1'b1;
							state_d = bks_pkg::ST_IDLE;
						end
						default: begin
							// insert of a key already held
							done_d  = 1'b1;
							ok_d    = 1'b0;
							state_d = bks_pkg::ST_IDLE;
						end
					endcase
				end else if (last_cmp) begin
					cmp_vld_d = 1'b0;
					done_d    = 1'b1;
					state_d   = bks_pkg::ST_IDLE;
					if (cmd_q == bks_pkg::CMD_INSERT) begin
						// room was checked on acceptance
						ram_we  = 1'b1;
						count_d = count_q + ONE_CNT;
						ok_d    = 1'b1;
					end else begin
						ok_d = 1'b0;
					end
				end
			end

			bks_pkg::ST_SHIFT: begin
				// read entry j+1 now, write it to j in the next cycle
				ram_raddr = sh_rd_q[IDX_W-1:0];
				if (sh_issue) begin
					ram_re    = 1'b1;
					wr_pend_d = 1'b1;
					wr_addr_d = sh_rd_q[IDX_W-1:0] - IDX_W'(1);
					sh_rd_d   = sh_rd_q + ONE_CNT;
				end
				if (wr_pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = wr_addr_s1;
					ram_wdata = ram_rdata;
				end
				if (!sh_issue && !wr_pend_s1) begin
					count_d = count_m1;
					done_d  = 1'b1;
					ok_d    = 1'b1;
					state_d = bks_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = bks_pkg::ST_IDLE;
			end
		endcase
	end

	// fill count is reported masked to the field width
	always_ff @(posedge clk) begin
		if (done_d) begin
			fill_wide_q <= {{bks_pkg::FILL_W{1'b0}}, count_d};
		end
	end

	assign done           = done_q;
	assign rsp.ok         = ok_q;
	assign rsp.fill_count = fill_wide_q[bks_pkg::FILL_W-1:0];

endmodule

`default_nettype wire

// ----- sv/bks_checker.sv -----
// bks_checker: port-level assertions on bounded_key_set_core, bound to every instance
// depends on bks_pkg
`timescale 1ns / 1ps
`default_nettype none

module bks_checker #(
	parameter int CAPACITY = bks_pkg::CAPACITY_DEF
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          start,
	input wire logic          busy,
	input wire bks_pkg::req_t req,
	input wire logic          done,
	input wire bks_pkg::rsp_t rsp
);

	// an accepted transaction either answers at once or holds the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction neither answered nor busy");

	// a result only comes out when the block is ready again
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	// busy only ends with a result
	a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// fill count never exceeds capacity (checked only for capacities below 32)
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((CAPACITY >= 32) || (rsp.fill_count <= CAPACITY)))
		else $error("fill count beyond capacity");

	// no result while idle without a request the cycle before
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !(start && !busy)) |=> !done)
		else $error("result without a transaction");

endmodule

bind bounded_key_set_core bks_checker #(
	.CAPACITY(CAPACITY)
) u_bks_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.req   (req),
	.done  (done),
	.rsp   (rsp)
);

`default_nettype wire
